/* design/ght_pkg.sv */
package ght_pkg;

  // request codes
  localparam logic [1:0] REQ_CREATE  = 2'd0;
  localparam logic [1:0] REQ_DESTROY = 2'd1;
  localparam logic [1:0] REQ_RESOLVE = 2'd2;

  // result status codes
  localparam logic [1:0] STATUS_OK           = 2'd0;
  localparam logic [1:0] STATUS_INVALID      = 2'd1;
  localparam logic [1:0] STATUS_FULL         = 2'd2;
  localparam logic [1:0] STATUS_BACKING_FAIL = 2'd3;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  handle_index;
    logic [31:0] handle_generation;
    logic [63:0] entry_data;
    logic        backing_ok;
  } ght_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  out_index;
    logic [31:0] out_generation;
    logic [63:0] out_data;
  } ght_rsp_t;

  // controller to datapath
  typedef struct packed {
    logic       load;
    logic       pop;
    logic       take_fresh;
    logic       take_handle;
    logic       take_stack;
    logic       slot_wr;
    logic       pay_wr;
    logic       push;
    logic       emit;
    logic [1:0] status;
  } ght_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] req_type;
    logic       backing_ok;
    logic       stack_empty;
    logic       fresh_avail;
    logic       range_ok;
    logic       slot_live;
    logic       gen_match;
  } ght_sts_t;

endpackage

/* design/ght_ram.sv */
module ght_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/ght_ctrl.sv */
module ght_ctrl import ght_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  ght_sts_t sts_i,
  output ght_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_DECODE  = 3'd1;
  localparam logic [2:0] S_POP     = 3'd2;
  localparam logic [2:0] S_SLOT_RD = 3'd3;
  localparam logic [2:0] S_CHECK   = 3'd4;

  logic [2:0] state_q, state_d;
  logic       handle_good;

  assign handle_good = sts_i.slot_live && sts_i.gen_match;
  assign busy        = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts_i.req_type)
          REQ_CREATE: begin
            if (!sts_i.stack_empty) begin
              cmd_o.pop = 1'b1;
              state_d   = S_POP;
            end else if (sts_i.fresh_avail) begin
              cmd_o.take_fresh = 1'b1;
              state_d          = S_SLOT_RD;
            end else begin
              cmd_o.emit   = 1'b1;
              cmd_o.status = STATUS_FULL;
              state_d      = S_IDLE;
            end
          end
          REQ_DESTROY, REQ_RESOLVE: begin
            if (sts_i.range_ok) begin
              cmd_o.take_handle = 1'b1;
              state_d           = S_SLOT_RD;
            end else begin
              cmd_o.emit   = 1'b1;
              cmd_o.status = STATUS_INVALID;
              state_d      = S_IDLE;
            end
          end
          default: begin
            cmd_o.emit   = 1'b1;
            cmd_o.status = STATUS_INVALID;
            state_d      = S_IDLE;
          end
        endcase
      end
      S_POP: begin
        cmd_o.take_stack = 1'b1;
        state_d          = S_SLOT_RD;
      end
      S_SLOT_RD: begin
        state_d = S_CHECK;
      end
      S_CHECK: begin
        cmd_o.emit = 1'b1;
        state_d    = S_IDLE;
        unique case (sts_i.req_type)
          REQ_CREATE: begin
            cmd_o.slot_wr = 1'b1;
            if (sts_i.backing_ok) begin
              cmd_o.pay_wr = 1'b1;
              cmd_o.status = STATUS_OK;
            end else begin
              cmd_o.push   = 1'b1;
              cmd_o.status = STATUS_BACKING_FAIL;
            end
          end
          REQ_DESTROY: begin
            if (handle_good) begin
              cmd_o.slot_wr = 1'b1;
              cmd_o.push    = 1'b1;
              cmd_o.status  = STATUS_OK;
            end else begin
              cmd_o.status = STATUS_INVALID;
            end
          end
          default: begin
            cmd_o.status = handle_good ? STATUS_OK : STATUS_INVALID;
          end
        endcase
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_emit_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |=> state_q == S_IDLE)
    else $error("result emitted without returning to idle");

  a_accept_decodes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> state_q == S_DECODE)
    else $error("accepted transaction not decoded");

endmodule

/* design/ght_datapath.sv */
module ght_datapath import ght_pkg::*; #(
  parameter int SLOTS    = 256,
  parameter int GEN_BITS = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  ght_req_t req_i,
  input  ght_cmd_t cmd_i,
  output ght_sts_t sts_o,
  output ght_rsp_t rsp_o,
  output logic     rsp_valid_o
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;

  ght_req_t            req_q;
  logic [IDX_W-1:0]    idx_q;
  logic                fresh_q;
  logic [CNT_W-1:0]    fc_q;
  logic [CNT_W-1:0]    nf_q;
  ght_rsp_t            rsp_q;
  logic                rsp_valid_q;

  logic [GEN_BITS:0]   slot_rdata;
  logic [GEN_BITS:0]   slot_wdata;
  logic [63:0]         pay_rdata;
  logic [IDX_W-1:0]    stack_rdata;
  logic [IDX_W-1:0]    stack_raddr;
  logic                push_en;
  logic [GEN_BITS-1:0] old_gen;
  logic [GEN_BITS-1:0] new_gen;
  logic                create_ok;
  logic                resolve_ok;

  // live mark on top, generation below
  ght_ram #(.WIDTH(GEN_BITS + 1), .DEPTH(SLOTS)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.slot_wr),
    .waddr_i (idx_q),
    .wdata_i (slot_wdata),
    .raddr_i (idx_q),
    .rdata_o (slot_rdata)
  );

  ght_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_pay_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.pay_wr),
    .waddr_i (idx_q),
    .wdata_i (req_q.entry_data),
    .raddr_i (idx_q),
    .rdata_o (pay_rdata)
  );

  ght_ram #(.WIDTH(IDX_W), .DEPTH(SLOTS)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (push_en),
    .waddr_i (fc_q[IDX_W-1:0]),
    .wdata_i (idx_q),
    .raddr_i (stack_raddr),
    .rdata_o (stack_rdata)
  );

  assign stack_raddr = IDX_W'(fc_q - CNT_W'(1));
  assign push_en     = cmd_i.push && (fc_q != CNT_W'(SLOTS));

  // a fresh slot has never been written, its generation is zero
  assign old_gen = fresh_q ? '0 : slot_rdata[GEN_BITS-1:0];

  always_comb begin
    new_gen = old_gen + GEN_BITS'(1);
    if (new_gen == '0) begin
      new_gen = GEN_BITS'(1);
    end
  end

  assign slot_wdata = (req_q.req_type == REQ_CREATE) ? {req_q.backing_ok, new_gen}
                                                     : {1'b0, old_gen};

  assign sts_o.req_type    = req_q.req_type;
  assign sts_o.backing_ok  = req_q.backing_ok;
  assign sts_o.stack_empty = (fc_q == '0);
  assign sts_o.fresh_avail = (nf_q != CNT_W'(SLOTS));
  assign sts_o.range_ok    = (req_q.handle_index != 8'd0)
                          && (CMP_W'(req_q.handle_index) < CMP_W'(nf_q))
                          && (CMP_W'(req_q.handle_index) < CMP_W'(SLOTS));
  assign sts_o.slot_live   = slot_rdata[GEN_BITS];
  assign sts_o.gen_match   = (32'(slot_rdata[GEN_BITS-1:0]) == req_q.handle_generation);

  assign create_ok  = (cmd_i.status == STATUS_OK) && (req_q.req_type == REQ_CREATE);
  assign resolve_ok = (cmd_i.status == STATUS_OK) && (req_q.req_type == REQ_RESOLVE);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
    priority if (cmd_i.take_fresh) begin
      idx_q <= nf_q[IDX_W-1:0];
    end else if (cmd_i.take_handle) begin
      idx_q <= IDX_W'(req_q.handle_index);
    end else if (cmd_i.take_stack) begin
      idx_q <= stack_rdata;
    end else begin
      idx_q <= idx_q;
    end
    if (cmd_i.emit) begin
      rsp_q.status         <= cmd_i.status;
      rsp_q.out_index      <= create_ok ? 8'(idx_q) : 8'd0;
      rsp_q.out_generation <= create_ok ? 32'(new_gen) : 32'd0;
      rsp_q.out_data       <= resolve_ok ? pay_rdata : 64'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fresh_q     <= 1'b0;
      fc_q        <= '0;
      nf_q        <= CNT_W'(1);
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= cmd_i.emit;
      if (cmd_i.load) begin
        fresh_q <= 1'b0;
      end else if (cmd_i.take_fresh) begin
        fresh_q <= 1'b1;
      end
      if (cmd_i.take_fresh) begin
        nf_q <= nf_q + CNT_W'(1);
      end
      if (cmd_i.pop) begin
        fc_q <= fc_q - CNT_W'(1);
      end else if (push_en) begin
        fc_q <= fc_q + CNT_W'(1);
      end
    end
  end

  assign rsp_o       = rsp_q;
  assign rsp_valid_o = rsp_valid_q;

  // free slots are distinct and all below next_fresh, slot zero excluded
  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fc_q < nf_q)
    else $error("free stack deeper than handed-out slots");

  a_create_gen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && rsp_q.status == STATUS_OK && req_q.req_type == REQ_CREATE)
    |-> rsp_q.out_generation != 32'd0)
    else $error("created handle carries generation zero");

endmodule

/* design/generational_handle_table.sv */
// generational handle table: create hands out a handle (slot index, generation)
// from a stack of freed slots or the next never-used slot (slot 0 is never
// used); destroy and resolve check the handle's index, generation and live
// mark. a transaction is accepted when start is high and busy is low; every
// transaction gives exactly one result, shown for one cycle with result_valid_o
// high, and the receiver must take it then: there is no back-pressure. a
// result for a handle whose index is out of range, a full table or an unused
// request code is given straight from decode; destroy, resolve and a create
// from a fresh slot go on through the slot read and the check, and a create
// that reuses a freed slot first pops the free stack; busy drops in the cycle
// the result is shown, so a new transaction can be accepted then. the order of
// steps is set by the registered-read slot memory and free-stack memory, which
// are read and then written in turn. no clearing pass is needed after reset.
module generational_handle_table import ght_pkg::*; #(
  parameter int SLOTS    = 256,
  parameter int GEN_BITS = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  ght_req_t req_i,
  output ght_rsp_t rsp_o,
  output logic     result_valid_o
);

  // command and status between the sequencer and the slot datapath
  ght_cmd_t cmd;
  ght_sts_t sts;

  // sequencer: decode, stack pop, slot read, check and write back
  ght_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // slot memory, payload memory, free stack and the result register
  ght_datapath #(
    .SLOTS    (SLOTS),
    .GEN_BITS (GEN_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .rsp_o       (rsp_o),
    .rsp_valid_o (result_valid_o)
  );

endmodule

/* bench/generational_handle_table_tb.sv */
module generational_handle_table_tb;
  import ght_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 256;
  localparam int RAND_PER_PHASE = 284;
  // no accepted request and no result for this long means the block has hung
  localparam int QUIET_LIMIT = 2000;
  // request code the block does not define
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam logic [63:0] PAT_A = 64'hA5A5_A5A5_A5A5_A5A5;
  localparam logic [63:0] PAT_B = 64'h5A5A_5A5A_5A5A_5A5A;
  localparam logic [63:0] ONES  = '1;

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  logic     busy;
  ght_req_t req_i;
  ght_rsp_t rsp_o;
  logic     result_valid_o;

  generational_handle_table #(
    .SLOTS(SLOTS),
    .GEN_BITS(32)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .req_i(req_i),
    .rsp_o(rsp_o),
    .result_valid_o(result_valid_o)
  );

  // directed stimulus row; has_rsp marks a response typed in by hand
  typedef struct {
    ght_req_t req;
    bit       has_rsp;
    ght_rsp_t rsp;
  } stim_row_t;

  // mirror of the table contents
  logic [31:0] slot_gen_m     [SLOTS];
  bit          slot_live_m    [SLOTS];
  logic [63:0] slot_payload_m [SLOTS];
  int          free_slots_m   [SLOTS];
  int          free_depth;
  int          fresh_next;
  int          live_count;

  ght_rsp_t  awaited_rsp_q[$];
  ght_rsp_t  head_rsp;
  stim_row_t dir_tab[$];

  int errors;
  int idle_pct;
  int quiet_cycles;
  int status_seen[4];
  int full_hits;
  int transactions;
  bit growing;

  // clock, 10 ns period
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // handle check: index in range, slot live, generation equal over all bits
  function automatic bit handle_matches(logic [7:0] idx, logic [31:0] gen);
    return idx != 8'd0 && int'(idx) < fresh_next && slot_live_m[idx] &&
           slot_gen_m[idx] == gen;
  endfunction

  function automatic void push_free_slot(int idx);
    if (free_depth < SLOTS) begin
      free_slots_m[free_depth] = idx;
      free_depth++;
    end
  endfunction

  // applies one request to the mirror and returns the response it must give
  function automatic ght_rsp_t apply_handle_op(ght_req_t r);
    ght_rsp_t    o;
    int          idx;
    bit          got;
    logic [31:0] g;
    o = '0;
    o.status = STATUS_INVALID;
    case (r.req_type)
      REQ_CREATE: begin
        got = 1'b0;
        idx = 0;
        // freed slots first, most recent on top; else a never-used slot
        if (free_depth > 0) begin
          free_depth--;
          idx = free_slots_m[free_depth];
          got = 1'b1;
        end else if (fresh_next < SLOTS) begin
          idx = fresh_next;
          fresh_next++;
          got = 1'b1;
        end
        if (!got) begin
          o.status = STATUS_FULL;
          full_hits++;
        end else begin
          // generation wraps past zero to one
          g = slot_gen_m[idx] + 32'd1;
          if (g == 32'd0) g = 32'd1;
          slot_gen_m[idx] = g;
          if (r.backing_ok) begin
            slot_live_m[idx] = 1'b1;
            slot_payload_m[idx] = r.entry_data;
            live_count++;
            o.status = STATUS_OK;
            o.out_index = idx[7:0];
            o.out_generation = g;
          end else begin
            // backing failed: slot burned a generation and goes back
            slot_live_m[idx] = 1'b0;
            push_free_slot(idx);
            o.status = STATUS_BACKING_FAIL;
          end
        end
      end
      REQ_DESTROY: begin
        if (handle_matches(r.handle_index, r.handle_generation)) begin
          slot_live_m[r.handle_index] = 1'b0;
          push_free_slot(int'(r.handle_index));
          live_count--;
          o.status = STATUS_OK;
        end
      end
      REQ_RESOLVE: begin
        if (handle_matches(r.handle_index, r.handle_generation)) begin
          o.out_data = slot_payload_m[r.handle_index];
          o.status = STATUS_OK;
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  // random live slot, 0 when none is live
  function automatic int pick_live_slot();
    int first;
    int idx;
    if (live_count == 0) return 0;
    first = $urandom_range(SLOTS - 1);
    for (int k = 0; k < SLOTS; k++) begin
      idx = (first + k) % SLOTS;
      if (slot_live_m[idx]) return idx;
    end
    return 0;
  endfunction

  // mostly well-formed traffic on live handles; the table is filled until it
  // reports full three times, then drained to eight live slots or fewer, then filled again
  function automatic ght_req_t random_req();
    ght_req_t r;
    int       roll;
    int       slot;
    int       idx;
    r.req_type = REQ_CREATE;
    r.handle_index = 8'($urandom_range(255));
    r.handle_generation = $urandom;
    r.entry_data = {$urandom, $urandom};
    r.backing_ok = ($urandom_range(99) < 85);
    if (growing && full_hits >= 3) growing = 1'b0;
    if (!growing && live_count <= 8) begin
      growing = 1'b1;
      full_hits = 0;
    end
    roll = $urandom_range(99);
    slot = pick_live_slot();
    if (roll < (growing ? 80 : 15)) return r;
    if (slot != 0 && roll < (growing ? 97 : 95)) begin
      r.req_type = (roll < (growing ? 88 : 35)) ? REQ_RESOLVE : REQ_DESTROY;
      r.handle_index = 8'(slot);
      r.handle_generation = slot_gen_m[slot];
      return r;
    end
    // broken handles and the unused code
    r.req_type = $urandom_range(1) ? REQ_RESOLVE : REQ_DESTROY;
    case ($urandom_range(3))
      0: r.req_type = REQ_UNUSED;
      1: ;
      2: begin
        if (slot != 0) begin
          r.handle_index = 8'(slot);
          r.handle_generation = slot_gen_m[slot] ^ (32'd1 << $urandom_range(31));
        end
      end
      default: begin
        // a freed slot or the first never-used one, with its own generation
        if (free_depth > 0) idx = free_slots_m[free_depth - 1];
        else if (fresh_next < SLOTS) idx = fresh_next;
        else idx = 0;
        r.handle_index = 8'(idx);
        r.handle_generation = slot_gen_m[idx];
      end
    endcase
    return r;
  endfunction

  function automatic stim_row_t mk_row(logic [1:0] t, logic [7:0] idx, logic [31:0] gen,
                                       logic [63:0] data, logic ok, bit has_rsp,
                                       logic [1:0] st, logic [7:0] oidx,
                                       logic [31:0] ogen, logic [63:0] odata);
    stim_row_t row;
    row.req = '{req_type: t, handle_index: idx, handle_generation: gen,
                entry_data: data, backing_ok: ok};
    row.has_rsp = has_rsp;
    row.rsp = '{status: st, out_index: oidx, out_generation: ogen, out_data: odata};
    return row;
  endfunction

  // appends one row to the directed table
  function automatic void add_row(stim_row_t row);
    dir_tab.insert(dir_tab.size(), row);
  endfunction

  // offers one transaction after a random idle gap and holds it until taken
  task automatic send_item(input ght_req_t r, input bit has_rsp, input ght_rsp_t typed_rsp);
    ght_rsp_t predicted;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    // accepted at this edge
    predicted = apply_handle_op(r);
    status_seen[predicted.status]++;
    transactions++;
    awaited_rsp_q.insert(awaited_rsp_q.size(), has_rsp ? typed_rsp : predicted);
  endtask

  // hold off new transactions until every response is back
  task automatic drain_responses();
    start <= 1'b0;
    while (awaited_rsp_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic void compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
    end
  endfunction

  // response checker: every strobed response against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (awaited_rsp_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected response, expected none, got %h", $time, rsp_o);
      end else begin
        head_rsp = awaited_rsp_q.pop_front();
        compare_field("status", 64'(head_rsp.status), 64'(rsp_o.status));
        compare_field("out_index", 64'(head_rsp.out_index), 64'(rsp_o.out_index));
        compare_field("out_generation", 64'(head_rsp.out_generation),
                      64'(rsp_o.out_generation));
        compare_field("out_data", head_rsp.out_data, rsp_o.out_data);
      end
    end
  end

  // watchdog: cycles with neither an accepted request nor a response
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || result_valid_o) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    ght_req_t next_req;
    rst_ni = 1'b0;
    start = 1'b0;
    req_i = '0;
    errors = 0;
    quiet_cycles = 0;
    full_hits = 0;
    transactions = 0;
    growing = 1'b1;
    idle_pct = 17;
    for (int s = 0; s < SLOTS; s++) begin
      slot_gen_m[s] = '0;
      slot_live_m[s] = 1'b0;
      slot_payload_m[s] = '0;
      free_slots_m[s] = 0;
    end
    for (int s = 0; s < 4; s++) status_seen[s] = 0;
    free_depth = 0;
    fresh_next = 1;
    live_count = 0;

    // directed walk from reset: empty table, reuse order, stale handles,
    // backing failures, ignored fields and the unused code
    add_row(mk_row(REQ_RESOLVE, 8'd0, 32'd0, '0, 1'b0,
                   1, STATUS_INVALID, 8'd0, 32'd0, '0));
    add_row(mk_row(REQ_DESTROY, 8'd0, 32'd0, ONES, 1'b1,
                   1, STATUS_INVALID, 8'd0, 32'd0, '0));
    add_row(mk_row(REQ_DESTROY, 8'd1, 32'd0, '0, 1'b0,
                   1, STATUS_INVALID, 8'd0, 32'd0, '0));
    add_row(mk_row(REQ_UNUSED, 8'd0, 32'd0, '0, 1'b0,
                   1, STATUS_INVALID, 8'd0, 32'd0, '0));
    add_row(mk_row(REQ_CREATE, 8'd0, 32'd0, ONES, 1'b1,
                   1, STATUS_OK, 8'd1, 32'd1, '0));
    add_row(mk_row(REQ_CREATE, 8'hFF, 32'hFFFF_FFFF, '0, 1'b1,
                   1, STATUS_OK, 8'd2, 32'd1, '0));
    add_row(mk_row(REQ_CREATE, 8'd0, 32'd0, PAT_A, 1'b0,
                   1, STATUS_BACKING_FAIL, 8'd0, 32'd0, '0));
    add_row(mk_row(REQ_CREATE, 8'd0, 32'd0, PAT_A, 1'b1,
                   1, STATUS_OK, 8'd3, 32'd2, '0));
    add_row(mk_row(REQ_RESOLVE, 8'd1, 32'd1, '0, 1'b0,
                   1, STATUS_OK, 8'd0, 32'd0, ONES));
    add_row(mk_row(REQ_RESOLVE, 8'd2, 32'd1, ONES, 1'b1,
                   1, STATUS_OK, 8'd0, 32'd0, '0));
    add_row(mk_row(REQ_RESOLVE, 8'd2, 32'd2, '0, 1'b0,
                   1, STATUS_INVALID, 8'd0, 32'd0, '0));
    add_row(mk_row(REQ_RESOLVE, 8'hFF, 32'hFFFF_FFFF, '0, 1'b0,
                   1, STATUS_INVALID, 8'd0, 32'd0, '0));
    add_row(mk_row(REQ_RESOLVE, 8'd4, 32'd1, '0, 1'b0,
                   1, STATUS_INVALID, 8'd0, 32'd0, '0));
    add_row(mk_row(REQ_DESTROY, 8'd3, 32'd1, '0, 1'b0,
                   1, STATUS_INVALID, 8'd0, 32'd0, '0));
    add_row(mk_row(REQ_DESTROY, 8'd1, 32'd1, '0, 1'b0,
                   1, STATUS_OK, 8'd0, 32'd0, '0));
    add_row(mk_row(REQ_DESTROY, 8'd1, 32'd1, '0, 1'b0,
                   1, STATUS_INVALID, 8'd0, 32'd0, '0));
    add_row(mk_row(REQ_RESOLVE, 8'd1, 32'd1, '0, 1'b0,
                   1, STATUS_INVALID, 8'd0, 32'd0, '0));
    add_row(mk_row(REQ_CREATE, 8'd0, 32'd0, PAT_B, 1'b1,
                   1, STATUS_OK, 8'd1, 32'd2, '0));
    add_row(mk_row(REQ_CREATE, 8'd0, 32'd0, '0, 1'b0,
                   1, STATUS_BACKING_FAIL, 8'd0, 32'd0, '0));
    add_row(mk_row(REQ_CREATE, 8'd0, 32'd0, '0, 1'b0,
                   1, STATUS_BACKING_FAIL, 8'd0, 32'd0, '0));
    add_row(mk_row(REQ_CREATE, 8'd0, 32'd0, ONES, 1'b1,
                   1, STATUS_OK, 8'd4, 32'd3, '0));
    add_row(mk_row(REQ_RESOLVE, 8'd3, 32'd2, '0, 1'b0,
                   0, STATUS_OK, 8'd0, 32'd0, '0));
    add_row(mk_row(REQ_DESTROY, 8'd2, 32'd1, ONES, 1'b0,
                   1, STATUS_OK, 8'd0, 32'd0, '0));
    add_row(mk_row(REQ_RESOLVE, 8'd1, 32'd2, '0, 1'b0,
                   0, STATUS_OK, 8'd0, 32'd0, '0));
    add_row(mk_row(REQ_UNUSED, 8'hFF, 32'hFFFF_FFFF, ONES, 1'b1,
                   1, STATUS_INVALID, 8'd0, 32'd0, '0));

    // reset is held low, then released at a clock edge
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[n]) send_item(dir_tab[n].req, dir_tab[n].has_rsp, dir_tab[n].rsp);
    drain_responses();

    // random phases: light sender gaps, heavy sender gaps, back to back
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 17 : (ph == 1) ? 53 : 0;
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        next_req = random_req();
        send_item(next_req, 1'b0, '0);
      end
      drain_responses();
    end

    // idle on afterwards to catch any stray response
    repeat (10) @(posedge clk_i);

    $display("%0d transactions: %0d ok, %0d invalid handle, %0d table full, %0d backing failed",
             transactions, status_seen[STATUS_OK], status_seen[STATUS_INVALID],
             status_seen[STATUS_FULL], status_seen[STATUS_BACKING_FAIL]);
    $display("fill and drain cycles over three sender gap profiles, %0d mismatches", errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
design/ght_pkg.sv
design/ght_ram.sv
design/ght_ctrl.sv
design/ght_datapath.sv
design/generational_handle_table.sv
bench/generational_handle_table_tb.sv
